FILE: rtl/core/ogb_pkg.sv
`default_nettype none
package ogb_pkg;
  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;
  localparam int COUNT_BITS_DEF = 16;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [1:0] {
    CMD_MAP_POINT = 2'd0,
    CMD_MAP_DONE = 2'd1,
    CMD_SCAN_POINT = 2'd2,
    CMD_READ_CELL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_CELL_SIZE = 3'd2,
    REG_GRID_WIDTH = 3'd3,
    REG_GRID_HEIGHT = 3'd4,
    REG_Z_LOW = 3'd5,
    REG_Z_HIGH = 3'd6,
    REG_FULL_SCORE = 3'd7
  } reg_idx_t;

  localparam logic signed [7:0] OCC_UNKNOWN = -8'sd1;
  localparam logic [7:0] OCC_FULL = 8'd100;

  typedef struct packed {
    logic [1:0] cmd;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0] cell_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic signed [7:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic [15:0] cell_size;
    logic [8:0] grid_width;
    logic [8:0] grid_height;
    logic signed [31:0] z_low;
    logic signed [31:0] z_high;
    logic [15:0] full_count;
  } cfg_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_DIV,
    FR_CHECK,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_CALC,
    BK_DIV,
    BK_WRITE,
    BK_CLEAR,
    BK_OUT
  } back_state_t;
endpackage
`default_nettype wire

FILE: rtl/core/ogb_ram.sv
`default_nettype none
module ogb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/ogb_front.sv
`default_nettype none
// classifies items; points get their cell by two serial divides done in parallel
module ogb_front #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS = 256,
  localparam int CELL_BITS = $clog2(MAX_COLUMNS * MAX_ROWS)
) (
  input wire logic clk,
  input wire logic rst,
  input wire ogb_pkg::cfg_t cfg,
  input wire logic in_valid,
  output logic in_stall,
  input wire ogb_pkg::in_item_t in_item,
  output logic q_valid,
  input wire logic q_full,
  output logic [1:0] q_cmd,
  output logic [1:0] q_status,
  output logic q_band,
  output logic [CELL_BITS-1:0] q_cell
);
  import ogb_pkg::*;
  localparam int CB = $clog2(MAX_COLUMNS + 1);
  localparam int RB = $clog2(MAX_ROWS + 1);

  front_state_t state, state_next;
  in_item_t item;
  logic [32:0] qx, qy;
  logic [15:0] remx, remy;
  logic [5:0] step;
  logic dead;
  logic [CB-1:0] cols;
  logic [RB-1:0] rows;
  logic [CELL_BITS-1:0] lin;
  logic [CELL_BITS:0] total;
  logic [32:0] rx, ry;
  logic [16:0] tx, ty;
  logic ok;

  assign cols = (32'(cfg.grid_width) > 32'(MAX_COLUMNS)) ? CB'(MAX_COLUMNS)
                                                         : CB'(cfg.grid_width);
  assign rows = (32'(cfg.grid_height) > 32'(MAX_ROWS)) ? RB'(MAX_ROWS)
                                                       : RB'(cfg.grid_height);
  assign total = (CELL_BITS+1)'(cols) * (CELL_BITS+1)'(rows);
  assign rx = 33'(item.px) - 33'(cfg.x_origin) + 33'd0;
  assign ry = 33'(item.py) - 33'(cfg.y_origin);
  assign tx = {remx, qx[32]};
  assign ty = {remy, qy[32]};
  assign ok = !dead && cols != '0 && rows != '0 && qx[31:0] < 32'(cols)
              && qy[31:0] < 32'(rows);
  assign lin = CELL_BITS'(qy[RB-1:0]) * CELL_BITS'(cols) + CELL_BITS'(qx[CB-1:0]);

  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: if (in_valid) begin
        if (in_item.cmd == CMD_MAP_POINT || in_item.cmd == CMD_SCAN_POINT) begin
          state_next = FR_DIV;
        end else begin
          state_next = FR_PUSH;
        end
      end
      FR_DIV: if (step == 6'd33) state_next = FR_CHECK;
      FR_CHECK: state_next = FR_PUSH;
      FR_PUSH: if (!q_full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != FR_IDLE);
    q_valid = (state == FR_PUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      FR_IDLE: begin
        item <= in_item;
        step <= '0;
        q_cmd <= in_item.cmd;
        q_status <= ST_ACCEPTED;
        q_cell <= CELL_BITS'(in_item.cell_number);
        q_band <= 1'b0;
        if (in_item.cmd == CMD_READ_CELL) begin
          if (32'(in_item.cell_number) >= 32'(total)) begin
            q_status <= ST_OUTSIDE;
          end
        end
      end
      FR_DIV: begin
        if (step == 6'd0) begin
          dead <= rx[32] || ry[32] || cfg.cell_size == 16'd0;
          qx <= {rx[31:0], 1'b0} >> 1;
          qy <= {ry[31:0], 1'b0} >> 1;
          remx <= '0;
          remy <= '0;
          step <= 6'd1;
        end else begin
          remx <= 16'((tx >= {1'b0, cfg.cell_size}) ? tx - {1'b0, cfg.cell_size} : tx);
          remy <= 16'((ty >= {1'b0, cfg.cell_size}) ? ty - {1'b0, cfg.cell_size} : ty);
          qx <= {qx[31:0], tx >= {1'b0, cfg.cell_size}};
          qy <= {qy[31:0], ty >= {1'b0, cfg.cell_size}};
          step <= step + 6'd1;
        end
      end
      FR_CHECK: begin
        q_cell <= lin;
        q_band <= (item.pz >= cfg.z_low) && (item.pz <= cfg.z_high);
        q_status <= ok ? ST_ACCEPTED : ST_OUTSIDE;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/core/ogb_back.sv
`default_nettype none
// carries out queued commands on the cell stores and computes occupancy
module ogb_back #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS = 256,
  parameter int COUNT_BITS = 16,
  localparam int CELLS = MAX_COLUMNS * MAX_ROWS,
  localparam int CELL_BITS = $clog2(CELLS)
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic [15:0] full_count,
  input wire logic q_valid,
  output logic q_pop,
  input wire logic [1:0] q_cmd,
  input wire logic [1:0] q_status,
  input wire logic q_band,
  input wire logic [CELL_BITS-1:0] q_cell,
  output logic busy_clear,
  output logic res_valid,
  input wire logic res_stall,
  output ogb_pkg::out_item_t res
);
  import ogb_pkg::*;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  back_state_t state, state_next;
  logic locked;
  logic [1:0] cmd, status;
  logic band;
  logic [CELL_BITS-1:0] cur_cell, clr;
  logic [COUNT_BITS-1:0] st_rd, sc_rd, st_wd, sc_wd, cnt;
  logic pr_rd, we_st, we_sc, we_pr, pr_wd;
  logic [CELL_BITS-1:0] waddr, raddr;
  logic [COUNT_BITS+6:0] num, quo;
  logic [15:0] rem;
  logic [16:0] t;
  logic [5:0] step;
  logic [7:0] occ;

  ogb_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_static (
    .clk, .we(we_st), .waddr, .wdata(st_wd), .raddr, .rdata(st_rd));
  ogb_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_scan (
    .clk, .we(we_sc), .waddr, .wdata(sc_wd), .raddr, .rdata(sc_rd));
  ogb_ram #(.WIDTH(1), .DEPTH(CELLS)) u_present (
    .clk, .we(we_pr), .waddr, .wdata(pr_wd), .raddr, .rdata(pr_rd));

  // queue head while idle, the cell in work afterwards
  assign raddr = (state == BK_IDLE) ? q_cell : cur_cell;
  assign cnt = (st_rd > sc_rd) ? st_rd : sc_rd;
  assign t = {rem, num[COUNT_BITS+6]};
  assign busy_clear = (state == BK_CLEAR);
  assign q_pop = (state == BK_IDLE) && q_valid;

  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: if (clr == CELL_BITS'(CELLS - 1)) state_next = BK_IDLE;
      BK_IDLE: if (q_valid) state_next = BK_READ;
      BK_READ: state_next = BK_CALC;
      BK_CALC: state_next = (cmd == CMD_READ_CELL && status == ST_ACCEPTED && pr_rd
                             && cnt != '0 && full_count != 16'd0) ? BK_DIV : BK_WRITE;
      BK_DIV: if (step == 6'(COUNT_BITS + 7)) state_next = BK_WRITE;
      BK_WRITE: state_next = BK_OUT;
      BK_OUT: if (!res_stall) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    res_valid = (state == BK_OUT);
    we_st = 1'b0;
    we_sc = 1'b0;
    we_pr = 1'b0;
    waddr = cur_cell;
    st_wd = (st_rd == CMAX) ? CMAX : st_rd + 1'b1;
    sc_wd = (sc_rd == CMAX) ? CMAX : sc_rd + 1'b1;
    pr_wd = 1'b1;
    if (state == BK_CLEAR) begin
      waddr = clr;
      we_st = 1'b1;
      we_sc = 1'b1;
      we_pr = 1'b1;
      st_wd = '0;
      sc_wd = '0;
      pr_wd = 1'b0;
    end else if (state == BK_WRITE && status == ST_ACCEPTED) begin
      case (cmd)
        CMD_MAP_POINT: begin
          we_pr = 1'b1;
          we_st = band;
        end
        CMD_SCAN_POINT: we_sc = band;
        CMD_READ_CELL: begin
          we_sc = 1'b1;
          sc_wd = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
      clr <= '0;
      locked <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) clr <= clr + 1'b1;
      if (state == BK_READ && cmd == CMD_MAP_DONE) locked <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        cmd <= q_cmd;
        status <= q_status;
        band <= q_band;
        cur_cell <= q_cell;
      end
      BK_READ: begin
        if (cmd == CMD_MAP_POINT && locked) status <= ST_IGNORED;
        if (cmd == CMD_SCAN_POINT && !locked) status <= ST_IGNORED;
        if (cmd == CMD_MAP_DONE) status <= ST_ACCEPTED;
      end
      BK_CALC: begin
        num <= (COUNT_BITS+7)'(cnt) * (COUNT_BITS+7)'(100);
        rem <= '0;
        step <= '0;
        occ <= '0;
        if (cmd == CMD_READ_CELL) begin
          if (status != ST_ACCEPTED || !pr_rd) occ <= OCC_UNKNOWN;
          else if (cnt == '0) occ <= 8'd0;
          else if (full_count == 16'd0) occ <= OCC_FULL;
        end
      end
      BK_DIV: begin
        if (step == 6'(COUNT_BITS + 7)) begin
          if (quo == '0) occ <= 8'd1;
          else if (quo > (COUNT_BITS+7)'(100)) occ <= OCC_FULL;
          else occ <= quo[7:0];
        end else begin
          rem <= 16'((t >= {1'b0, full_count}) ? t - {1'b0, full_count} : t);
          quo <= {quo[COUNT_BITS+5:0], t >= {1'b0, full_count}};
          num <= num << 1;
          step <= step + 6'd1;
        end
      end
      BK_WRITE: begin
        res.status <= status;
        res.occupancy <= occ;
      end
      default: ;
    endcase
  end

  initial_check: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid) else $error("result dropped");
  pop_once: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !q_pop) else $error("double pop");
  no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    busy_clear |-> !q_pop && !res_valid) else $error("work during clear");
endmodule
`default_nettype wire

FILE: rtl/core/point_cloud_occupancy_grid_binner_unit.sv
`default_nettype none
// occupancy grid binner: a point request holds the front through a setup
// step, two 33-step serial divides by cell_size run side by side, a range
// check and the push into the queue, so the front takes no new request until
// the last one is pushed; other requests go straight to the push. after the
// pop the back runs a serial divide of count*100 only for an in-range
// read_cell of a present cell with a nonzero count and a nonzero full count,
// and each result may wait on out_stall. a one-entry queue between front and
// back lets them overlap. after reset a clearing pass sweeps every cell of
// the cell stores before any request is taken.
module point_cloud_occupancy_grid_binner_unit #(
  parameter int MAX_COLUMNS = ogb_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS = ogb_pkg::MAX_ROWS_DEF,
  parameter int COUNT_BITS = ogb_pkg::COUNT_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire ogb_pkg::in_item_t in_data,
  output logic out_valid,
  input wire logic out_stall,
  output ogb_pkg::out_item_t out_data,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [ogb_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input wire logic [31:0] cfg_value
);
  import ogb_pkg::*;
  localparam int CELL_BITS = $clog2(MAX_COLUMNS * MAX_ROWS);

  cfg_t cfg;
  logic f_valid, f_stall, clearing, q_pop;
  logic [1:0] f_cmd, f_status;
  logic f_band;
  logic [CELL_BITS-1:0] f_cell;
  // one-entry queue between front and back
  logic qv;
  logic [1:0] qcmd, qst;
  logic qband;
  logic [CELL_BITS-1:0] qcell;
  logic fe_stall;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin <= '0;
      cfg.y_origin <= '0;
      cfg.cell_size <= 16'd51;
      cfg.grid_width <= 9'd256;
      cfg.grid_height <= 9'd256;
      cfg.z_low <= -32'sd205;
      cfg.z_high <= 32'sd512;
      cfg.full_count <= 16'd10;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X: cfg.x_origin <= cfg_value;
        REG_ORIGIN_Y: cfg.y_origin <= cfg_value;
        REG_CELL_SIZE: cfg.cell_size <= cfg_value[15:0];
        REG_GRID_WIDTH: cfg.grid_width <= cfg_value[8:0];
        REG_GRID_HEIGHT: cfg.grid_height <= cfg_value[8:0];
        REG_Z_LOW: cfg.z_low <= cfg_value;
        REG_Z_HIGH: cfg.z_high <= cfg_value;
        REG_FULL_SCORE: cfg.full_count <= cfg_value[15:0];
        default: ;
      endcase
    end
  end

  // front holds off while the stores are being cleared
  assign in_stall = fe_stall || clearing;

  ogb_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk, .rst, .cfg, .in_valid(in_valid && !clearing), .in_stall(fe_stall),
    .in_item(in_data), .q_valid(f_valid), .q_full(f_stall), .q_cmd(f_cmd),
    .q_status(f_status), .q_band(f_band), .q_cell(f_cell));

  assign f_stall = qv;

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
    end else if (f_valid && !qv) begin
      qv <= 1'b1;
    end else if (q_pop) begin
      qv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (f_valid && !qv) begin
      qcmd <= f_cmd;
      qst <= f_status;
      qband <= f_band;
      qcell <= f_cell;
    end
  end

  ogb_back #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst, .full_count(cfg.full_count), .q_valid(qv), .q_pop, .q_cmd(qcmd),
    .q_status(qst), .q_band(qband), .q_cell(qcell), .busy_clear(clearing),
    .res_valid(out_valid), .res_stall(out_stall), .res(out_data));
endmodule
`default_nettype wire
